>>> design/wssc_pkg.sv
package wssc_pkg;

  localparam int ADC_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int THRESH_W   = 12;
  localparam int GAIN_W     = 8;
  localparam int LIMIT_W    = 15;
  localparam int DRIVE_W    = 16;
  localparam int DONE_W     = 2;
  localparam int WALL_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STEER_THRESH_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_THRESH_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_LIMIT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESH_FR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESH_FL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESH_R      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESH_L      = 3'd7;

  localparam logic [THRESH_W-1:0] RST_STEER_THRESH = 12'd20;
  localparam logic [GAIN_W-1:0]   RST_STEER_GAIN   = 8'd1;
  localparam logic [LIMIT_W-1:0]  RST_STEER_LIMIT  = 15'd1000;
  localparam logic [THRESH_W-1:0] RST_WALL_THRESH  = 12'd2048;

  localparam logic [WALL_W-1:0] FRONT_WALL_BITS = 8'h88;
  localparam logic [WALL_W-1:0] RIGHT_WALL_BITS = 8'h44;
  localparam logic [WALL_W-1:0] LEFT_WALL_BITS  = 8'h11;

  localparam logic [DONE_W-1:0] DONE_SENSE   = 2'd0;
  localparam logic [DONE_W-1:0] DONE_FRONT   = 2'd1;
  localparam logic [DONE_W-1:0] DONE_STEER   = 2'd2;
  localparam logic [DONE_W-1:0] DONE_CAPTURE = 2'd3;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  typedef enum logic [2:0] {
    PH_SENSE = 3'b001,
    PH_FRONT = 3'b010,
    PH_STEER = 3'b100
  } phase_t;

  typedef struct packed {
    logic [DONE_W-1:0]         phase_done;
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;
    logic [WALL_W-1:0]         wall_bits;
  } res_t;

endpackage

>>> design/wall_sensor_steering_correction_top.sv
// an accepted beat's result is registered in the output register, or in the
// skid register on a stall; one beat per cycle while in_ready is high; all
// work sits between state and output registers, with products precomputed
// from the next state; a skid register keeps in_ready high for one stalled
// result; reset (rst_n low, synchronous): sense phase, readings, baselines,
// corrections zero, registers at their defaults, no result pending
module wall_sensor_steering_correction_top #(
  parameter int ADC_BITS = wssc_pkg::ADC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [wssc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wssc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic [ADC_BITS-1:0]                   in_sample_a,
  input  logic [ADC_BITS-1:0]                   in_sample_b,
  input  logic                                  in_ctrl_enable,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [wssc_pkg::DONE_W-1:0]           out_phase_done,
  output logic signed [wssc_pkg::DRIVE_W-1:0]   out_drive_left,
  output logic signed [wssc_pkg::DRIVE_W-1:0]   out_drive_right,
  output logic [wssc_pkg::WALL_W-1:0]           out_wall_bits
);

  localparam int DW = ADC_BITS + 1;
  localparam int CW = ((DW > wssc_pkg::THRESH_W + 1) ? DW : wssc_pkg::THRESH_W + 1) + 1;
  localparam int PW = ADC_BITS + 10;
  localparam int SW = PW + 1;
  localparam int WW = (ADC_BITS > wssc_pkg::THRESH_W) ? ADC_BITS : wssc_pkg::THRESH_W;

  // configuration registers
  logic [wssc_pkg::THRESH_W-1:0] st_thl_r, st_thl_nxt;
  logic [wssc_pkg::THRESH_W-1:0] st_thr_r, st_thr_nxt;
  logic [wssc_pkg::GAIN_W-1:0]   gain_r, gain_nxt;
  logic [wssc_pkg::LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [wssc_pkg::THRESH_W-1:0] wt_fr_r, wt_fr_nxt;
  logic [wssc_pkg::THRESH_W-1:0] wt_fl_r, wt_fl_nxt;
  logic [wssc_pkg::THRESH_W-1:0] wt_r_r, wt_r_nxt;
  logic [wssc_pkg::THRESH_W-1:0] wt_l_r, wt_l_nxt;

  always_comb begin
    st_thl_nxt = st_thl_r;
    st_thr_nxt = st_thr_r;
    gain_nxt   = gain_r;
    limit_nxt  = limit_r;
    wt_fr_nxt  = wt_fr_r;
    wt_fl_nxt  = wt_fl_r;
    wt_r_nxt   = wt_r_r;
    wt_l_nxt   = wt_l_r;
    if (cfg_we) begin
      unique case (cfg_index)
        wssc_pkg::REG_STEER_THRESH_LEFT:  st_thl_nxt = cfg_wdata[wssc_pkg::THRESH_W-1:0];
        wssc_pkg::REG_STEER_THRESH_RIGHT: st_thr_nxt = cfg_wdata[wssc_pkg::THRESH_W-1:0];
        wssc_pkg::REG_STEER_GAIN:         gain_nxt   = cfg_wdata[wssc_pkg::GAIN_W-1:0];
        wssc_pkg::REG_STEER_LIMIT:        limit_nxt  = cfg_wdata[wssc_pkg::LIMIT_W-1:0];
        wssc_pkg::REG_WALL_THRESH_FR:     wt_fr_nxt  = cfg_wdata[wssc_pkg::THRESH_W-1:0];
        wssc_pkg::REG_WALL_THRESH_FL:     wt_fl_nxt  = cfg_wdata[wssc_pkg::THRESH_W-1:0];
        wssc_pkg::REG_WALL_THRESH_R:      wt_r_nxt   = cfg_wdata[wssc_pkg::THRESH_W-1:0];
        wssc_pkg::REG_WALL_THRESH_L:      wt_l_nxt   = cfg_wdata[wssc_pkg::THRESH_W-1:0];
      endcase
    end
  end

  // block state
  wssc_pkg::phase_t phase_r, phase_nxt;
  logic [ADC_BITS-1:0] rd_r_r, rd_r_nxt;
  logic [ADC_BITS-1:0] rd_l_r, rd_l_nxt;
  logic [ADC_BITS-1:0] rd_fr_r, rd_fr_nxt;
  logic [ADC_BITS-1:0] rd_fl_r, rd_fl_nxt;
  logic [ADC_BITS-1:0] base_l_r, base_l_nxt;
  logic [ADC_BITS-1:0] base_r_r, base_r_nxt;
  logic signed [wssc_pkg::DRIVE_W-1:0] corr_l_r, corr_l_nxt;
  logic signed [wssc_pkg::DRIVE_W-1:0] corr_r_r, corr_r_nxt;

  // products and side selects for the state left by this cycle
  logic signed [PW-1:0] prod_l_r, prod_l_nxt;
  logic signed [PW-1:0] prod_r_r, prod_r_nxt;
  logic                 sel_l_r, sel_l_nxt;
  logic                 sel_r_r, sel_r_nxt;

  // output register and skid
  wssc_pkg::res_t out_res_r, skid_res_r, res_nxt;
  logic           out_valid_r, skid_valid_r;

  logic acc;
  logic pop;
  logic [wssc_pkg::DONE_W-1:0] done;

  logic signed [SW-1:0] sum_l, sum_r, lim_p, lim_n, clamp_l, clamp_r;
  logic signed [DW-1:0] dif_l, dif_r;
  logic signed [PW-1:0] gain_s;
  logic [wssc_pkg::WALL_W-1:0] wall;

  assign in_ready = !skid_valid_r;
  assign acc      = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // steering sums from the precomputed products
  always_comb begin
    sum_l = '0;
    sum_r = '0;
    if (sel_l_r) begin
      sum_l = sum_l + SW'(prod_l_r);
      sum_r = sum_r - SW'(prod_l_r);
    end
    if (sel_r_r) begin
      sum_l = sum_l - SW'(prod_r_r);
      sum_r = sum_r + SW'(prod_r_r);
    end
    lim_p = $signed(SW'({1'b0, limit_r}));
    lim_n = -lim_p;
    if (sum_l > lim_p) begin
      clamp_l = lim_p;
    end else if (sum_l < lim_n) begin
      clamp_l = lim_n;
    end else begin
      clamp_l = sum_l;
    end
    if (sum_r > lim_p) begin
      clamp_r = lim_p;
    end else if (sum_r < lim_n) begin
      clamp_r = lim_n;
    end else begin
      clamp_r = sum_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    rd_r_nxt   = rd_r_r;
    rd_l_nxt   = rd_l_r;
    rd_fr_nxt  = rd_fr_r;
    rd_fl_nxt  = rd_fl_r;
    base_l_nxt = base_l_r;
    base_r_nxt = base_r_r;
    corr_l_nxt = corr_l_r;
    corr_r_nxt = corr_r_r;
    done       = wssc_pkg::DONE_CAPTURE;
    if (in_op == wssc_pkg::OP_CAPTURE) begin
      base_l_nxt = rd_l_r;
      base_r_nxt = rd_r_r;
    end else begin
      unique case (phase_r)
        wssc_pkg::PH_SENSE: begin
          done      = wssc_pkg::DONE_SENSE;
          rd_r_nxt  = in_sample_a;
          rd_l_nxt  = in_sample_b;
          phase_nxt = wssc_pkg::PH_FRONT;
        end
        wssc_pkg::PH_FRONT: begin
          done      = wssc_pkg::DONE_FRONT;
          rd_fr_nxt = in_sample_a;
          rd_fl_nxt = in_sample_b;
          phase_nxt = wssc_pkg::PH_STEER;
        end
        wssc_pkg::PH_STEER: begin
          done      = wssc_pkg::DONE_STEER;
          phase_nxt = wssc_pkg::PH_SENSE;
          if (in_ctrl_enable) begin
            corr_l_nxt = wssc_pkg::DRIVE_W'(clamp_l);
            corr_r_nxt = wssc_pkg::DRIVE_W'(clamp_r);
          end else begin
            corr_l_nxt = '0;
            corr_r_nxt = '0;
          end
        end
        default: begin
          done      = wssc_pkg::DONE_CAPTURE;
          phase_nxt = wssc_pkg::PH_SENSE;
        end
      endcase
    end
    if (!acc) begin
      phase_nxt  = phase_r;
      rd_r_nxt   = rd_r_r;
      rd_l_nxt   = rd_l_r;
      rd_fr_nxt  = rd_fr_r;
      rd_fl_nxt  = rd_fl_r;
      base_l_nxt = base_l_r;
      base_r_nxt = base_r_r;
      corr_l_nxt = corr_l_r;
      corr_r_nxt = corr_r_r;
    end
  end

  // products for the next cycle's state
  always_comb begin
    dif_l      = $signed({1'b0, rd_l_nxt}) - $signed({1'b0, base_l_nxt});
    dif_r      = $signed({1'b0, rd_r_nxt}) - $signed({1'b0, base_r_nxt});
    gain_s     = PW'($signed({1'b0, gain_nxt}));
    prod_l_nxt = PW'(dif_l) * gain_s;
    prod_r_nxt = PW'(dif_r) * gain_s;
    sel_l_nxt  = CW'(dif_l) > $signed(CW'({1'b0, st_thl_nxt}));
    sel_r_nxt  = CW'(dif_r) > $signed(CW'({1'b0, st_thr_nxt}));
  end

  always_comb begin
    wall = '0;
    if ((WW'(rd_fr_nxt) > WW'(wt_fr_r)) || (WW'(rd_fl_nxt) > WW'(wt_fl_r))) begin
      wall = wall | wssc_pkg::FRONT_WALL_BITS;
    end
    if (WW'(rd_r_nxt) > WW'(wt_r_r)) begin
      wall = wall | wssc_pkg::RIGHT_WALL_BITS;
    end
    if (WW'(rd_l_nxt) > WW'(wt_l_r)) begin
      wall = wall | wssc_pkg::LEFT_WALL_BITS;
    end
    res_nxt.phase_done  = done;
    res_nxt.drive_left  = corr_l_nxt;
    res_nxt.drive_right = corr_r_nxt;
    res_nxt.wall_bits   = wall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_thl_r <= wssc_pkg::RST_STEER_THRESH;
      st_thr_r <= wssc_pkg::RST_STEER_THRESH;
      gain_r   <= wssc_pkg::RST_STEER_GAIN;
      limit_r  <= wssc_pkg::RST_STEER_LIMIT;
      wt_fr_r  <= wssc_pkg::RST_WALL_THRESH;
      wt_fl_r  <= wssc_pkg::RST_WALL_THRESH;
      wt_r_r   <= wssc_pkg::RST_WALL_THRESH;
      wt_l_r   <= wssc_pkg::RST_WALL_THRESH;
      phase_r  <= wssc_pkg::PH_SENSE;
      rd_r_r   <= '0;
      rd_l_r   <= '0;
      rd_fr_r  <= '0;
      rd_fl_r  <= '0;
      base_l_r <= '0;
      base_r_r <= '0;
      corr_l_r <= '0;
      corr_r_r <= '0;
      prod_l_r <= '0;
      prod_r_r <= '0;
      sel_l_r  <= 1'b0;
      sel_r_r  <= 1'b0;
    end else begin
      st_thl_r <= st_thl_nxt;
      st_thr_r <= st_thr_nxt;
      gain_r   <= gain_nxt;
      limit_r  <= limit_nxt;
      wt_fr_r  <= wt_fr_nxt;
      wt_fl_r  <= wt_fl_nxt;
      wt_r_r   <= wt_r_nxt;
      wt_l_r   <= wt_l_nxt;
      phase_r  <= phase_nxt;
      rd_r_r   <= rd_r_nxt;
      rd_l_r   <= rd_l_nxt;
      rd_fr_r  <= rd_fr_nxt;
      rd_fl_r  <= rd_fl_nxt;
      base_l_r <= base_l_nxt;
      base_r_r <= base_r_nxt;
      corr_l_r <= corr_l_nxt;
      corr_r_r <= corr_r_nxt;
      prod_l_r <= prod_l_nxt;
      prod_r_r <= prod_r_nxt;
      sel_l_r  <= sel_l_nxt;
      sel_r_r  <= sel_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else begin
        out_res_r <= res_nxt;
      end
    end else if (acc) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phase_done  = out_res_r.phase_done;
  assign out_drive_left  = out_res_r.drive_left;
  assign out_drive_right = out_res_r.drive_right;
  assign out_wall_bits   = out_res_r.wall_bits;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held with empty output register");

  a_drive_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.drive_left == -out_res_r.drive_right))
    else $error("wheel corrections not mirrored");

  a_capture_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_op == wssc_pkg::OP_CAPTURE)) |=> (phase_r == $past(phase_r)))
    else $error("capture beat moved the phase");

  a_disable_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_op == wssc_pkg::OP_TICK) && (phase_r == wssc_pkg::PH_STEER) &&
     !in_ctrl_enable) |=> ((corr_l_r == '0) && (corr_r_r == '0)))
    else $error("disabled steer tick left a nonzero correction");

endmodule

>>> test/tb_wall_sensor_steering_correction_top.sv
module tb_wall_sensor_steering_correction_top;

  localparam int ADC_W       = wssc_pkg::ADC_BITS_DEF;
  localparam int CYCLE_LIMIT = 300000;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [wssc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [wssc_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_op = wssc_pkg::OP_TICK;
  logic [ADC_W-1:0]                    in_sample_a = '0;
  logic [ADC_W-1:0]                    in_sample_b = '0;
  logic                                in_ctrl_enable = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [wssc_pkg::DONE_W-1:0]         out_phase_done;
  logic signed [wssc_pkg::DRIVE_W-1:0] out_drive_left;
  logic signed [wssc_pkg::DRIVE_W-1:0] out_drive_right;
  logic [wssc_pkg::WALL_W-1:0]         out_wall_bits;

  wall_sensor_steering_correction_top #(.ADC_BITS(ADC_W)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_sample_a    (in_sample_a),
    .in_sample_b    (in_sample_b),
    .in_ctrl_enable (in_ctrl_enable),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_phase_done (out_phase_done),
    .out_drive_left (out_drive_left),
    .out_drive_right(out_drive_right),
    .out_wall_bits  (out_wall_bits)
  );

  // register copy
  logic [wssc_pkg::THRESH_W-1:0] thr_left, thr_right;
  logic [wssc_pkg::GAIN_W-1:0]   steer_gain;
  logic [wssc_pkg::LIMIT_W-1:0]  steer_limit;
  logic [wssc_pkg::THRESH_W-1:0] wall_fr, wall_fl, wall_r, wall_l;

  // sensing state copy
  logic [wssc_pkg::DONE_W-1:0]         phase_q;
  logic [ADC_W-1:0]                    rd_right, rd_left, rd_front_right, rd_front_left;
  logic [ADC_W-1:0]                    base_right, base_left;
  logic signed [wssc_pkg::DRIVE_W-1:0] corr_left, corr_right;

  wssc_pkg::res_t expected_drive[$];
  wssc_pkg::res_t exp_beat;
  int   error_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("wall_sensor_steering_correction_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
             field, cycle_count, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_drive.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        exp_beat = expected_drive.pop_front();
        if (out_phase_done !== exp_beat.phase_done)
          report_mismatch("phase_done", out_phase_done, exp_beat.phase_done);
        if (out_drive_left !== exp_beat.drive_left)
          report_mismatch("drive_left", out_drive_left, exp_beat.drive_left);
        if (out_drive_right !== exp_beat.drive_right)
          report_mismatch("drive_right", out_drive_right, exp_beat.drive_right);
        if (out_wall_bits !== exp_beat.wall_bits)
          report_mismatch("wall_bits", out_wall_bits, exp_beat.wall_bits);
      end
    end
  end

  function automatic logic signed [wssc_pkg::DRIVE_W-1:0] clamp_drive(input int v);
    int lim;
    lim = int'(steer_limit);
    if (v > lim) return wssc_pkg::DRIVE_W'(lim);
    if (v < -lim) return wssc_pkg::DRIVE_W'(-lim);
    return wssc_pkg::DRIVE_W'(v);
  endfunction

  task automatic predict_beat(input logic op, input logic [ADC_W-1:0] a,
                              input logic [ADC_W-1:0] b, input logic en);
    wssc_pkg::res_t r;
    int   dif_l, dif_r, sum_l, sum_r, g;
    if (op == wssc_pkg::OP_CAPTURE) begin
      base_left  = rd_left;
      base_right = rd_right;
      r.phase_done = wssc_pkg::DONE_CAPTURE;
    end else begin
      r.phase_done = phase_q;
      case (phase_q)
        wssc_pkg::DONE_SENSE: begin
          rd_right = a;
          rd_left  = b;
        end
        wssc_pkg::DONE_FRONT: begin
          rd_front_right = a;
          rd_front_left  = b;
        end
        wssc_pkg::DONE_STEER: begin
          if (en) begin
            dif_l = int'(rd_left) - int'(base_left);
            dif_r = int'(rd_right) - int'(base_right);
            g = int'(steer_gain);
            sum_l = 0;
            sum_r = 0;
            if (dif_l > int'(thr_left)) begin
              sum_l += g * dif_l;
              sum_r -= g * dif_l;
            end
            if (dif_r > int'(thr_right)) begin
              sum_l -= g * dif_r;
              sum_r += g * dif_r;
            end
            corr_left  = clamp_drive(sum_l);
            corr_right = clamp_drive(sum_r);
          end else begin
            corr_left  = '0;
            corr_right = '0;
          end
        end
        default: ;
      endcase
      phase_q = (phase_q >= wssc_pkg::DONE_STEER) ? wssc_pkg::DONE_SENSE : phase_q + 2'd1;
    end
    r.drive_left  = corr_left;
    r.drive_right = corr_right;
    r.wall_bits   = '0;
    if (rd_front_right > wall_fr || rd_front_left > wall_fl)
      r.wall_bits |= wssc_pkg::FRONT_WALL_BITS;
    if (rd_right > wall_r) r.wall_bits |= wssc_pkg::RIGHT_WALL_BITS;
    if (rd_left > wall_l) r.wall_bits |= wssc_pkg::LEFT_WALL_BITS;
    expected_drive.push_back(r);
  endtask

  task automatic send_beat(input logic op, input int a, input int b, input logic en);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_sample_a    <= ADC_W'(a);
    in_sample_b    <= ADC_W'(b);
    in_ctrl_enable <= en;
    do @(posedge clk); while (!in_ready);
    predict_beat(op, ADC_W'(a), ADC_W'(b), en);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wssc_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[wssc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      wssc_pkg::REG_STEER_THRESH_LEFT:  thr_left    = val[wssc_pkg::THRESH_W-1:0];
      wssc_pkg::REG_STEER_THRESH_RIGHT: thr_right   = val[wssc_pkg::THRESH_W-1:0];
      wssc_pkg::REG_STEER_GAIN:         steer_gain  = val[wssc_pkg::GAIN_W-1:0];
      wssc_pkg::REG_STEER_LIMIT:        steer_limit = val[wssc_pkg::LIMIT_W-1:0];
      wssc_pkg::REG_WALL_THRESH_FR:     wall_fr     = val[wssc_pkg::THRESH_W-1:0];
      wssc_pkg::REG_WALL_THRESH_FL:     wall_fl     = val[wssc_pkg::THRESH_W-1:0];
      wssc_pkg::REG_WALL_THRESH_R:      wall_r      = val[wssc_pkg::THRESH_W-1:0];
      wssc_pkg::REG_WALL_THRESH_L:      wall_l      = val[wssc_pkg::THRESH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int tl, input int tr, input int g, input int lim,
                               input int fr, input int fl, input int r, input int l);
    write_reg(wssc_pkg::REG_STEER_THRESH_LEFT, tl);
    write_reg(wssc_pkg::REG_STEER_THRESH_RIGHT, tr);
    write_reg(wssc_pkg::REG_STEER_GAIN, g);
    write_reg(wssc_pkg::REG_STEER_LIMIT, lim);
    write_reg(wssc_pkg::REG_WALL_THRESH_FR, fr);
    write_reg(wssc_pkg::REG_WALL_THRESH_FL, fl);
    write_reg(wssc_pkg::REG_WALL_THRESH_R, r);
    write_reg(wssc_pkg::REG_WALL_THRESH_L, l);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one full sensing cycle; samples on the steering tick are junk
  task automatic sense_cycle(input int right, input int left, input int fr, input int fl,
                             input logic en);
    send_beat(wssc_pkg::OP_TICK, right, left, en);
    send_beat(wssc_pkg::OP_TICK, fr, fl, en);
    send_beat(wssc_pkg::OP_TICK, $urandom_range(4095), $urandom_range(4095), en);
  endtask

  task automatic test_default_settings();
    sense_cycle(4095, 0, 0, 4095, 1'b1);
    send_beat(wssc_pkg::OP_CAPTURE, 4095, 4095, 1'b1);
    // readings below baseline on the right
    sense_cycle(0, 4095, 4095, 0, 1'b1);
    // capture in the middle of a cycle, wall thresholds at the edge
    send_beat(wssc_pkg::OP_TICK, 2049, 2048, 1'b1);
    send_beat(wssc_pkg::OP_CAPTURE, 0, 0, 1'b0);
    send_beat(wssc_pkg::OP_TICK, 2048, 2049, 1'b1);
    send_beat(wssc_pkg::OP_TICK, 1234, 3210, 1'b0);
    // steering thresholds at the edge
    sense_cycle(2049 + 21, 2048 + 20, 0, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_steer_extremes();
    load_settings(0, 0, 255, 32767, 0, 0, 0, 0);
    sense_cycle(0, 0, 0, 0, 1'b1);
    send_beat(wssc_pkg::OP_CAPTURE, 4095, 4095, 1'b1);
    sense_cycle(4095, 0, 4095, 4095, 1'b1);
    sense_cycle(4095, 4095, 0, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_zero_limit_and_max_threshold();
    load_settings(0, 0, 255, 0, 4095, 4095, 4095, 4095);
    sense_cycle(4095, 4095, 4095, 4095, 1'b1);
    wait_idle();
    load_settings(4095, 4095, 255, 32767, 100, 200, 300, 400);
    sense_cycle(4095, 4095, 4095, 4095, 1'b1);
    wait_idle();
  endtask

  function automatic int pick_reading(input logic [ADC_W-1:0] base);
    case ($urandom_range(7))
      0: return 0;
      1: return 4095;
      2, 3, 4: return $urandom_range(4095);
      default: return (int'(base) + $urandom_range(60) - 10) & 12'hfff;
    endcase
  endfunction

  function automatic int pick_steer_thresh();
    case ($urandom_range(5))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(4095);
      default: return $urandom_range(40);
    endcase
  endfunction

  function automatic int pick_wall_thresh();
    case ($urandom_range(5))
      0: return 0;
      1: return 4095;
      default: return $urandom_range(4095);
    endcase
  endfunction

  task automatic random_settings();
    int g, lim;
    case ($urandom_range(4))
      0: g = 0;
      1: g = 255;
      2: g = $urandom_range(255);
      default: g = $urandom_range(1, 12);
    endcase
    case ($urandom_range(4))
      0: lim = 0;
      1: lim = 32767;
      2: lim = $urandom_range(32767);
      default: lim = $urandom_range(2000);
    endcase
    load_settings(pick_steer_thresh(), pick_steer_thresh(), g, lim,
                  pick_wall_thresh(), pick_wall_thresh(),
                  pick_wall_thresh(), pick_wall_thresh());
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    logic op;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      random_settings();
      repeat (85) begin
        op = ($urandom_range(99) < 12) ? wssc_pkg::OP_CAPTURE : wssc_pkg::OP_TICK;
        send_beat(op, pick_reading(base_right), pick_reading(base_left),
                  $urandom_range(99) < 85);
      end
      wait_idle();
    end
  endtask

  initial begin
    thr_left    = wssc_pkg::RST_STEER_THRESH;
    thr_right   = wssc_pkg::RST_STEER_THRESH;
    steer_gain  = wssc_pkg::RST_STEER_GAIN;
    steer_limit = wssc_pkg::RST_STEER_LIMIT;
    wall_fr     = wssc_pkg::RST_WALL_THRESH;
    wall_fl     = wssc_pkg::RST_WALL_THRESH;
    wall_r      = wssc_pkg::RST_WALL_THRESH;
    wall_l      = wssc_pkg::RST_WALL_THRESH;
    phase_q        = wssc_pkg::DONE_SENSE;
    rd_right       = '0;
    rd_left        = '0;
    rd_front_right = '0;
    rd_front_left  = '0;
    base_right     = '0;
    base_left      = '0;
    corr_left      = '0;
    corr_right     = '0;
    send_idle_pct  = 12;
    recv_idle_pct  = 75;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_default_settings();
    test_steer_extremes();
    test_zero_limit_and_max_threshold();
    test_random_traffic(12, 75);
    test_random_traffic(75, 12);
    test_random_traffic(0, 0);

    wait_idle();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("wall_sensor_steering_correction_top verification clean");
    end else begin
      $display("wall_sensor_steering_correction_top verification failed");
    end
    $finish;
  end

endmodule
